>>> rtl/core/wsq_pkg.sv
// Shared types and constants for the wind stow qualifier.
// Used by the front, queue, back and top-level modules; depends on nothing.
package wsq_pkg;

	// Speed conversion: ((adc * 12596) >> 8) - 4031, knots in signed Q8.8.
	localparam logic [23:0]        SPEED_GAIN   = 24'd12596;
	localparam logic signed [16:0] SPEED_OFFSET = 17'sd4031;

	// Configuration register indexes.
	localparam int unsigned  CFG_INDEX_W        = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_HOLD      = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_HOLD       = 2'd3;

	localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd8960;
	localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd7680;
	localparam logic [23:0] HIGH_HOLD_RESET      = 24'd15000;
	localparam logic [23:0] LOW_HOLD_RESET       = 24'd600000;

	// Depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified request as it leaves the front.
	typedef struct packed {
		logic signed [16:0] speed;
		logic [31:0]        now_ms;
		logic               above_high;
		logic               below_high;
		logic               above_low;
		logic               below_low;
		// Time compares against now_ms + hold, used when start is restarted to now_ms.
		logic               late_high_from_now;
		logic               early_high_from_now;
		logic               late_low_from_now;
		logic               early_low_from_now;
	} item_t;

endpackage

>>> rtl/core/wsq_front.sv
// Front end of the wind stow qualifier: speed conversion and threshold classification.
// Depends on wsq_pkg.
module wsq_front (
	input  logic [9:0]     adc_sample,
	input  logic [31:0]    now_ms,
	input  logic [15:0]    high_threshold,
	input  logic [15:0]    low_threshold,
	input  logic [23:0]    high_hold,
	input  logic [23:0]    low_hold,
	output wsq_pkg::item_t item
);

	logic [23:0]        product;
	logic [15:0]        scaled;
	logic signed [16:0] speed;
	logic signed [17:0] speed_x;
	logic signed [17:0] high_x;
	logic signed [17:0] low_x;
	logic [31:0]        now_plus_high;
	logic [31:0]        now_plus_low;

	assign product = {14'd0, adc_sample} * wsq_pkg::SPEED_GAIN;
	assign scaled  = product[23:8];
	assign speed   = $signed({1'b0, scaled}) - wsq_pkg::SPEED_OFFSET;

	// The thresholds are unsigned, so a negative speed lies below both.
	assign speed_x = {speed[16], speed};
	assign high_x  = $signed({2'b00, high_threshold});
	assign low_x   = $signed({2'b00, low_threshold});

	assign now_plus_high = now_ms + {8'd0, high_hold};
	assign now_plus_low  = now_ms + {8'd0, low_hold};

	always_comb begin
		item.speed               = speed;
		item.now_ms              = now_ms;
		item.above_high          = speed_x > high_x;
		item.below_high          = speed_x < high_x;
		item.above_low           = speed_x > low_x;
		item.below_low           = speed_x < low_x;
		item.late_high_from_now  = now_ms > now_plus_high;
		item.early_high_from_now = now_ms < now_plus_high;
		item.late_low_from_now   = now_ms > now_plus_low;
		item.early_low_from_now  = now_ms < now_plus_low;
	end

endmodule

>>> rtl/core/wsq_fifo.sv
// Short queue of classified requests between the front and the back.
// Depends on wsq_pkg for the entry type and depth.
module wsq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsq_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output wsq_pkg::item_t rd_item,
	output logic           empty
);

	wsq_pkg::item_t                     entry_q [wsq_pkg::QUEUE_DEPTH];
	logic [wsq_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [wsq_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [wsq_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = count_q == wsq_pkg::QUEUE_CNT_W'(wsq_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/wsq_back.sv
// Back end of the wind stow qualifier: the timed qualifier rules and the result register.
// Depends on wsq_pkg for the classified request type.
module wsq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wsq_pkg::item_t     item,
	input  logic               item_valid,
	output logic               item_take,
	input  logic [23:0]        high_hold,
	input  logic [23:0]        low_hold,
	input  logic               pop,
	output logic               empty,
	output logic               safe_flag,
	output logic signed [16:0] speed_knots
);

	logic        safe_q;
	logic        high_timing_q;
	logic        low_timing_q;
	logic [31:0] start_ms_q;
	logic        out_valid_q;
	logic        safe_out_q;
	logic signed [16:0] speed_out_q;

	logic [31:0] start_plus_high;
	logic [31:0] start_plus_low;
	logic        late_high;
	logic        early_high;
	logic        late_low;
	logic        early_low;
	logic        rule1, rule2, rule3, rule4, rule5, rule6;
	logic        high_timing_1, high_timing_2, high_timing_3;
	logic        low_timing_4, low_timing_5, low_timing_6;
	logic        safe_2, safe_5;
	logic        start_from_now;
	logic [31:0] start_next;

	assign item_take = item_valid && (!out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign safe_flag   = safe_out_q;
	assign speed_knots = speed_out_q;

	assign start_plus_high = start_ms_q + {8'd0, high_hold};
	assign start_plus_low  = start_ms_q + {8'd0, low_hold};

	always_comb begin
		rule1         = !high_timing_q && item.above_high;
		high_timing_1 = high_timing_q || rule1;
		// Once the high qualifier restarts, its window is measured from now.
		late_high     = rule1 ? item.late_high_from_now  : (item.now_ms > start_plus_high);
		early_high    = rule1 ? item.early_high_from_now : (item.now_ms < start_plus_high);

		rule2         = high_timing_1 && late_high;
		safe_2        = rule2 ? 1'b0 : safe_q;
		high_timing_2 = high_timing_1 && !rule2;
		rule3         = high_timing_2 && item.below_high && early_high;
		high_timing_3 = high_timing_2 && !rule3;

		rule4          = !low_timing_q && !safe_2 && item.below_low;
		low_timing_4   = low_timing_q || rule4;
		// The start register is shared, so either restart moves the low window too.
		start_from_now = rule1 || rule4;
		late_low       = start_from_now ? item.late_low_from_now
		                                : (item.now_ms > start_plus_low);
		early_low      = start_from_now ? item.early_low_from_now
		                                : (item.now_ms < start_plus_low);

		rule5        = low_timing_4 && late_low;
		safe_5       = rule5 ? 1'b1 : safe_2;
		low_timing_5 = low_timing_4 && !rule5;
		rule6        = low_timing_5 && item.above_low && early_low;
		low_timing_6 = low_timing_5 && !rule6;

		start_next = start_from_now ? item.now_ms : start_ms_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q        <= 1'b0;
			high_timing_q <= 1'b0;
			low_timing_q  <= 1'b0;
			start_ms_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (item_take) begin
				safe_q        <= safe_5;
				high_timing_q <= high_timing_3;
				low_timing_q  <= low_timing_6;
				start_ms_q    <= start_next;
				out_valid_q   <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			safe_out_q  <= safe_5;
			speed_out_q <= item.speed;
		end
	end

endmodule

>>> rtl/core/wind_stow_qualifier.sv
// Top level of the wind stow qualifier: configuration registers and the front/queue/back chain.
// Depends on wsq_pkg, wsq_front, wsq_fifo and wsq_back.
//
//   Channel   Ports                                   Transfer when
//   input     push, full, adc_sample, now_ms          push && !full
//   result    pop, empty, safe_flag, speed_knots      pop && !empty
//   config    cfg_write, cfg_index, cfg_data          cfg_write
//
// One request per cycle is sustained while results are popped. A request is classified
// combinationally as it is pushed into a four-entry queue; the back end moves one per cycle
// into the result register while that register is empty or popped, so a result passes
// through a queue entry and then the result register to the result ports. Reset clears the
// qualifier state, the queue and the result valid flag, and loads the default thresholds
// and hold times. A stalled result holds the back end; the queue then fills and full rises.
module wind_stow_qualifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [9:0]                          adc_sample,
	input  logic [31:0]                         now_ms,
	input  logic                                pop,
	output logic                                empty,
	output logic                                safe_flag,
	output logic signed [16:0]                  speed_knots,
	input  logic                                cfg_write,
	input  logic [wsq_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [23:0]                         cfg_data
);

	logic [15:0]    high_threshold_q;
	logic [15:0]    low_threshold_q;
	logic [23:0]    high_hold_q;
	logic [23:0]    low_hold_q;
	wsq_pkg::item_t front_item;
	wsq_pkg::item_t queue_item;
	logic           queue_empty;
	logic           back_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_threshold_q <= wsq_pkg::HIGH_THRESHOLD_RESET;
			low_threshold_q  <= wsq_pkg::LOW_THRESHOLD_RESET;
			high_hold_q      <= wsq_pkg::HIGH_HOLD_RESET;
			low_hold_q       <= wsq_pkg::LOW_HOLD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				wsq_pkg::REG_HIGH_THRESHOLD: high_threshold_q <= cfg_data[15:0];
				wsq_pkg::REG_LOW_THRESHOLD:  low_threshold_q  <= cfg_data[15:0];
				wsq_pkg::REG_HIGH_HOLD:      high_hold_q      <= cfg_data;
				wsq_pkg::REG_LOW_HOLD:       low_hold_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wsq_front u_front (
		.adc_sample     (adc_sample),
		.now_ms         (now_ms),
		.high_threshold (high_threshold_q),
		.low_threshold  (low_threshold_q),
		.high_hold      (high_hold_q),
		.low_hold       (low_hold_q),
		.item           (front_item)
	);

	wsq_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (back_take),
		.rd_item (queue_item),
		.empty   (queue_empty)
	);

	wsq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (queue_item),
		.item_valid  (!queue_empty),
		.item_take   (back_take),
		.high_hold   (high_hold_q),
		.low_hold    (low_hold_q),
		.pop         (pop),
		.empty       (empty),
		.safe_flag   (safe_flag),
		.speed_knots (speed_knots)
	);

endmodule

>>> test/tb_top.sv
// Self-checking testbench for wind_stow_qualifier: queue-style request and result sides.
// Depends on wsq_pkg and the wind_stow_qualifier top level; predicts every result internally.
module tb_top;

	localparam int IDLE_LIMIT = 1000;

	typedef enum int {WIND_GUST, WIND_CALM, WIND_MIXED, WIND_NOISE} wind_kind_t;

	// Tracks the qualifier state and the results still owed by the block.
	class stow_scoreboard;
		logic [15:0]        high_thr;
		logic [15:0]        low_thr;
		logic [23:0]        high_hold;
		logic [23:0]        low_hold;
		bit                 safe;
		bit                 high_on;
		bit                 low_on;
		logic [31:0]        start_ms;
		bit                 safe_q[$];
		logic signed [16:0] knots_q[$];
		int                 mismatches;

		function new();
			high_thr   = wsq_pkg::HIGH_THRESHOLD_RESET;
			low_thr    = wsq_pkg::LOW_THRESHOLD_RESET;
			high_hold  = wsq_pkg::HIGH_HOLD_RESET;
			low_hold   = wsq_pkg::LOW_HOLD_RESET;
			safe       = 1'b0;
			high_on    = 1'b0;
			low_on     = 1'b0;
			start_ms   = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [wsq_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] data);
			case (idx)
				wsq_pkg::REG_HIGH_THRESHOLD: high_thr = data[15:0];
				wsq_pkg::REG_LOW_THRESHOLD:  low_thr = data[15:0];
				wsq_pkg::REG_HIGH_HOLD:      high_hold = data;
				wsq_pkg::REG_LOW_HOLD:       low_hold = data;
				default: ;
			endcase
		endfunction

		function int knots_of(logic [9:0] adc);
			return int'((32'(adc) * 32'(wsq_pkg::SPEED_GAIN)) >> 8)
				- int'(wsq_pkg::SPEED_OFFSET);
		endfunction

		function int pending();
			return safe_q.size();
		endfunction

		function void note_sample(logic [9:0] adc, logic [31:0] t);
			int s;
			int hi;
			int lo;
			s  = knots_of(adc);
			hi = int'(high_thr);
			lo = int'(low_thr);
			// The two qualifiers share start_ms; the order of the rules matters.
			if (!high_on && s > hi) begin
				high_on  = 1'b1;
				start_ms = t;
			end
			if (high_on && t > start_ms + 32'(high_hold)) begin
				safe    = 1'b0;
				high_on = 1'b0;
			end
			if (high_on && s < hi && t < start_ms + 32'(high_hold))
				high_on = 1'b0;
			if (!low_on && !safe && s < lo) begin
				low_on   = 1'b1;
				start_ms = t;
			end
			if (low_on && t > start_ms + 32'(low_hold)) begin
				safe   = 1'b1;
				low_on = 1'b0;
			end
			if (low_on && s > lo && t < start_ms + 32'(low_hold))
				low_on = 1'b0;
			safe_q.push_back(safe);
			knots_q.push_back(s[16:0]);
		endfunction

		function void check_result(logic safe_act, logic signed [16:0] knots_act);
			logic               safe_exp;
			logic signed [16:0] knots_exp;
			if (safe_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: safe_flag=%0b speed_knots=%0d",
						safe_act, knots_act);
				return;
			end
			safe_exp  = safe_q.pop_front();
			knots_exp = knots_q.pop_front();
			if (safe_act !== safe_exp || knots_act !== knots_exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: safe_flag exp %0b got %0b, speed_knots exp %0d got %0d",
						safe_exp, safe_act, knots_exp, knots_act);
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            push = 1'b0;
	logic                            full;
	logic [9:0]                      adc_sample = '0;
	logic [31:0]                     now_ms = '0;
	logic                            pop = 1'b0;
	logic                            empty;
	logic                            safe_flag;
	logic signed [16:0]              speed_knots;
	logic                            cfg_write = 1'b0;
	logic [wsq_pkg::CFG_INDEX_W-1:0] cfg_index = wsq_pkg::REG_HIGH_THRESHOLD;
	logic [23:0]                     cfg_data = '0;

	stow_scoreboard sb = new();

	int          burst_left = 0;
	int          gust_adc_min = 1023;
	int          calm_adc_max = 0;
	logic [31:0] clock_ms = '0;
	logic [15:0] pop_pattern = 16'hFFFF;
	int          pattern_age = 0;
	int          idle_cycles = 0;

	wind_stow_qualifier u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.adc_sample  (adc_sample),
		.now_ms      (now_ms),
		.pop         (pop),
		.empty       (empty),
		.safe_flag   (safe_flag),
		.speed_knots (speed_knots),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one request; returns at the edge that takes it, or after a pause that ends a burst.
	task automatic push_sample(input logic [9:0] adc, input logic [31:0] t);
		int gap;
		push <= 1'b1;
		adc_sample <= adc;
		now_ms <= t;
		@(negedge clk);
		while (full)
			@(negedge clk);
		sb.note_sample(adc, t);
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(0, 25);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [wsq_pkg::CFG_INDEX_W-1:0] idx,
			input logic [23:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_settings(input logic [15:0] hi, input logic [15:0] lo,
			input logic [23:0] hh, input logic [23:0] lh);
		wait_drained();
		// Upper bits of a threshold write are not part of the register.
		write_cfg(wsq_pkg::REG_HIGH_THRESHOLD, {8'($urandom), hi});
		write_cfg(wsq_pkg::REG_LOW_THRESHOLD, {8'($urandom), lo});
		write_cfg(wsq_pkg::REG_HIGH_HOLD, hh);
		write_cfg(wsq_pkg::REG_LOW_HOLD, lh);
		cfg_write <= 1'b0;
		gust_adc_min = 1023;
		for (int a = 1023; a >= 0; a--)
			if (sb.knots_of(10'(a)) > int'(sb.high_thr))
				gust_adc_min = a;
		calm_adc_max = 0;
		for (int a = 0; a < 1024; a++)
			if (sb.knots_of(10'(a)) < int'(sb.low_thr))
				calm_adc_max = a;
	endtask

	task automatic run_episode(input wind_kind_t kind, input int count);
		logic [9:0]  adc;
		logic [31:0] t;
		logic [23:0] hold;
		for (int i = 0; i < count; i++) begin
			case (kind)
				WIND_GUST: adc = 10'($urandom_range(gust_adc_min, 1023));
				WIND_CALM: adc = 10'($urandom_range(0, calm_adc_max));
				default:   adc = 10'($urandom_range(0, 1023));
			endcase
			hold = (kind == WIND_CALM) ? sb.low_hold : sb.high_hold;
			if (kind == WIND_NOISE) begin
				t = $urandom;
			end else if ($urandom_range(0, 7) == 0) begin
				// Land on or right beside the end of a running hold time.
				hold = $urandom_range(0, 1) ? sb.low_hold : sb.high_hold;
				t = sb.start_ms + 32'(hold) + 32'($urandom_range(0, 2)) - 32'd1;
			end else begin
				t = clock_ms + 32'($urandom_range(0, hold / 3 + 2));
			end
			clock_ms = t;
			push_sample(adc, t);
		end
	endtask

	// Receiver stalls follow a rotating mask that is replaced now and then.
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0:       pop_pattern = 16'hFFFF;
				1:       pop_pattern = 16'($urandom & $urandom & $urandom) | 16'd1;
				default: pop_pattern = 16'($urandom) | 16'd1;
			endcase
			pattern_age = $urandom_range(20, 120);
		end
		pattern_age--;
		pop <= pop_pattern[0];
		pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
	end

	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(safe_flag, speed_knots);
	end

	always @(negedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("wind_stow_qualifier verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          left;
		int          n;
		int          r;
		wind_kind_t  kind;
		logic [15:0] hi;
		logic [15:0] lo;
		logic [23:0] hh;
		logic [23:0] lh;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: calm qualifies exactly past the hold, then a gust trips stow.
		push_sample(10'd0, 32'd0);
		push_sample(10'd0, 32'd600000);
		push_sample(10'd0, 32'd600001);
		push_sample(10'd1023, 32'd600002);
		push_sample(10'd1023, 32'd615002);
		push_sample(10'd1023, 32'd615003);
		// Start at the top of the counter, so the hold end wraps past zero.
		push_sample(10'd1023, 32'hFFFF_FFFF);
		push_sample(10'd512, 32'd1000);

		// Thresholds equal to reachable speeds; zero hold times.
		apply_settings(16'(sb.knots_of(10'd300)), 16'(sb.knots_of(10'd250)), 24'd0, 24'd0);
		push_sample(10'd300, 32'd5);
		push_sample(10'd250, 32'd6);
		push_sample(10'd301, 32'd7);
		push_sample(10'd301, 32'd8);
		push_sample(10'd249, 32'd9);
		push_sample(10'd249, 32'd10);

		// Zero thresholds make negative speeds the only calm ones.
		apply_settings(16'd0, 16'd0, 24'hFF_FFFF, 24'hFF_FFFF);
		push_sample(10'd0, 32'hFFFF_0000);
		push_sample(10'd81, 32'hFFFF_0001);
		push_sample(10'd1023, 32'h0000_FFFF);

		// Thresholds above the largest speed.
		apply_settings(16'd49151, 16'd49151, 24'd0, 24'd0);
		push_sample(10'd1023, 32'd12345);
		push_sample(10'd1023, 32'd12346);

		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin
					hi = wsq_pkg::HIGH_THRESHOLD_RESET;
					lo = wsq_pkg::LOW_THRESHOLD_RESET;
					hh = wsq_pkg::HIGH_HOLD_RESET;
					lh = wsq_pkg::LOW_HOLD_RESET;
				end
				1: begin
					hi = 16'd0;
					lo = 16'd0;
					hh = 24'd0;
					lh = 24'd0;
				end
				2: begin
					hi = 16'd49151;
					lo = 16'd49151;
					hh = 24'hFF_FFFF;
					lh = 24'hFF_FFFF;
				end
				3: begin
					hi = 16'd49151;
					lo = 16'd0;
					hh = 24'hFF_FFFF;
					lh = 24'd0;
				end
				default: begin
					hi = 16'($urandom_range(1000, 30000));
					lo = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40000))
						: 16'($urandom_range(0, hi));
					r = $urandom_range(0, 4);
					hh = (r == 0) ? 24'hFF_FFFF : (r == 1) ? 24'd0
						: 24'($urandom_range(0, 4000));
					r = $urandom_range(0, 4);
					lh = (r == 0) ? 24'hFF_FFFF : (r == 1) ? 24'd0
						: 24'($urandom_range(0, 8000));
				end
			endcase
			apply_settings(hi, lo, hh, lh);
			if ($urandom_range(0, 2) == 0)
				clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000000));
			else
				clock_ms = $urandom;
			left = 120;
			while (left > 0) begin
				r = $urandom_range(0, 9);
				if (r < 4)
					kind = WIND_GUST;
				else if (r < 8)
					kind = WIND_CALM;
				else if (r == 8)
					kind = WIND_MIXED;
				else
					kind = WIND_NOISE;
				n = $urandom_range(2, 30);
				if (n > left)
					n = left;
				run_episode(kind, n);
				left -= n;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("wind_stow_qualifier verification clean");
		else
			$display("wind_stow_qualifier verification failed");
		$finish;
	end

endmodule
